// ===== sv/cle_pkg.sv =====
// Shared types and constants of the canonical line editor.
`default_nettype none
package cle_pkg;

	localparam int LEN_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 6;

	localparam logic [LEN_W-1:0] LIMIT_RST = 6'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	localparam logic [7:0] CH_INTR = 8'd3;
	localparam logic [7:0] CH_EOF = 8'd4;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_FF = 8'd12;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_KLINE = 8'd21;
	localparam logic [7:0] CH_KWORD = 8'd23;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DEL = 8'd127;

	typedef enum logic [2:0] {
		K_ECHO = 3'd0,
		K_ERASE = 3'd1,
		K_CLEAR = 3'd2,
		K_LINE = 3'd3,
		K_EMPTY = 3'd4,
		K_EOF = 3'd5,
		K_INTR = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic [LEN_W-1:0] erase_count;
		logic last;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/cle_if.sv =====
// Request channel interfaces for received bytes and editor results.
`default_nettype none
interface cle_in_if;
	logic valid;
	logic ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface cle_out_if;
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic [7:0] data;
	logic [5:0] erase_count;
	logic last;

	modport source (output valid, output kind, output data, output erase_count,
		output last, input ready);
	modport sink (input valid, input kind, input data, input erase_count,
		input last, output ready);
endinterface
`default_nettype wire

// ===== sv/canonical_line_editor_core.sv =====
// Top level of the canonical line editor: sequencer, line memory and result register.
//
//   Channel  Direction  Payload                          Request taken when
//   rx       in         ch                               rx.valid && rx.ready
//   tx       out        kind, data, erase_count, last    tx.valid && tx.ready
//   cfg      in         cfg_index, cfg_data              cfg_we
//
// A new byte is taken only in the idle state. A stored line is delivered by starting the
// memory read, then issuing one stored byte per cycle unless tx stalls, set by the single
// read port of the line memory; a raw byte after the line, or an empty line result after a
// clear, comes last. A word kill scans backward, one memory entry at a time, over spaces
// and then over the word. Reset clears the control state and loads the register defaults;
// the line memory is not cleared, since only entries below the line length are ever used.
// A stalled tx holds its result and pauses the sequencer; the next byte is taken as soon
// as the last result of the previous one sits in the output register.
`default_nettype none
module canonical_line_editor_core #(
	parameter int LINE_MAX = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cle_pkg::CFG_W-1:0] cfg_data,
	cle_in_if.sink rx,
	cle_out_if.source tx
);

	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

	logic out_v_q;
	cle_pkg::res_t out_q;
	logic out_free;
	logic push;
	cle_pkg::res_t push_res;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0] mem_rdata;

	assign out_free = !out_v_q || tx.ready;

	cle_ctrl #(
		.LINE_MAX(LINE_MAX),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx_valid(rx.valid),
		.rx_ch(rx.ch),
		.rx_ready(rx.ready),
		.out_free(out_free),
		.push(push),
		.push_res(push_res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	cle_line_mem #(
		.DEPTH(LINE_MAX),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_res;
		end
	end

	assign tx.valid = out_v_q;
	assign tx.kind = out_q.kind;
	assign tx.data = out_q.data;
	assign tx.erase_count = out_q.erase_count;
	assign tx.last = out_q.last;

endmodule
`default_nettype wire

// ===== sv/cle_line_mem.sv =====
// Line buffer memory with one write port and one registered read port.
`default_nettype none
module cle_line_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [7:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/cle_ctrl.sv =====
// Sequencer that decodes each byte, edits the line and issues results.
`default_nettype none
module cle_ctrl #(
	parameter int LINE_MAX = 32,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cle_pkg::CFG_W-1:0] cfg_data,
	input wire logic rx_valid,
	input wire logic [7:0] rx_ch,
	output logic rx_ready,
	input wire logic out_free,
	output logic push,
	output cle_pkg::res_t push_res,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0] mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input wire logic [7:0] mem_rdata
);

	localparam logic [cle_pkg::LEN_W-1:0] MaxLen = cle_pkg::LEN_W'(LINE_MAX);

	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_PEND, S_EMIT0, S_EMIT, S_TAIL, S_KW0, S_KW
	} state_t;

	state_t state_q;
	state_t after_pend;
	logic [7:0] ch_q;
	logic echo_q;
	logic canon_q;
	logic [cle_pkg::LEN_W-1:0] limit_q;
	logic [cle_pkg::LEN_W-1:0] len_q;
	logic [cle_pkg::LEN_W-1:0] k_q;
	logic [cle_pkg::LEN_W-1:0] before_q;
	logic phase_q;
	logic pend_v_q;
	cle_pkg::kind_t pend_kind_q;
	logic [7:0] pend_data_q;
	logic [cle_pkg::LEN_W-1:0] pend_cnt_q;
	logic emit_q;
	logic tail_v_q;
	cle_pkg::kind_t tail_kind_q;
	logic [7:0] tail_data_q;

	logic [cle_pkg::LEN_W-1:0] lim;
	logic [cle_pkg::LEN_W-1:0] new_len;
	logic [cle_pkg::LEN_W-1:0] raddr_full;
	logic [7:0] c_canon;
	logic is_plain;
	logic k_last;
	logic kw_space;
	logic kw_done;
	logic kw_dec;

	always_comb begin
		lim = limit_q;
		if (lim == '0) begin
			lim = cle_pkg::LEN_W'(1);
		end
		if (lim > MaxLen) begin
			lim = MaxLen;
		end
	end

	assign c_canon = (ch_q == cle_pkg::CH_CR) ? cle_pkg::CH_LF : ch_q;
	assign is_plain = !(c_canon inside {cle_pkg::CH_BS, cle_pkg::CH_DEL, cle_pkg::CH_KWORD,
		cle_pkg::CH_KLINE, cle_pkg::CH_FF, cle_pkg::CH_EOF, cle_pkg::CH_INTR});
	assign new_len = (len_q < MaxLen) ? len_q + cle_pkg::LEN_W'(1) : len_q;
	assign k_last = (k_q == len_q - cle_pkg::LEN_W'(1));
	assign kw_space = (mem_rdata == cle_pkg::CH_SPACE);
	assign kw_done = (len_q == '0) || (phase_q && kw_space);
	assign kw_dec = !kw_done && (phase_q ? !kw_space : kw_space);
	assign after_pend = (emit_q && len_q != '0) ? S_EMIT0 : (tail_v_q ? S_TAIL : S_IDLE);

	assign rx_ready = (state_q == S_IDLE);
	assign mem_we = (state_q == S_DEC) && canon_q && is_plain && (len_q < MaxLen);
	assign mem_waddr = len_q[AW-1:0];
	assign mem_wdata = c_canon;

	always_comb begin
		case (state_q)
			S_EMIT0: raddr_full = '0;
			S_EMIT: raddr_full = out_free ? k_q + cle_pkg::LEN_W'(1) : k_q;
			S_KW0: raddr_full = len_q - cle_pkg::LEN_W'(1);
			S_KW: raddr_full = kw_dec ? len_q - cle_pkg::LEN_W'(2) : len_q - cle_pkg::LEN_W'(1);
			default: raddr_full = '0;
		endcase
	end
	assign mem_raddr = raddr_full[AW-1:0];

	always_comb begin
		push = 1'b0;
		push_res.kind = pend_kind_q;
		push_res.data = pend_data_q;
		push_res.erase_count = pend_cnt_q;
		push_res.last = !(emit_q && len_q != '0) && !tail_v_q;
		case (state_q)
			S_PEND: begin
				push = pend_v_q && out_free;
			end
			S_EMIT: begin
				push = out_free;
				push_res.kind = cle_pkg::K_LINE;
				push_res.data = mem_rdata;
				push_res.erase_count = '0;
				push_res.last = k_last && !tail_v_q;
			end
			S_TAIL: begin
				push = out_free;
				push_res.kind = tail_kind_q;
				push_res.data = tail_data_q;
				push_res.erase_count = '0;
				push_res.last = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			echo_q <= 1'b1;
			canon_q <= 1'b1;
			limit_q <= cle_pkg::LIMIT_RST;
			len_q <= '0;
			k_q <= '0;
			before_q <= '0;
			phase_q <= 1'b0;
			pend_v_q <= 1'b0;
			emit_q <= 1'b0;
			tail_v_q <= 1'b0;
			ch_q <= '0;
			pend_kind_q <= cle_pkg::K_ECHO;
			pend_data_q <= '0;
			pend_cnt_q <= '0;
			tail_kind_q <= cle_pkg::K_LINE;
			tail_data_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cle_pkg::CFG_ECHO: echo_q <= cfg_data[0];
					cle_pkg::CFG_CANON: canon_q <= cfg_data[0];
					cle_pkg::CFG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (rx_valid) begin
						ch_q <= rx_ch;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					pend_v_q <= 1'b0;
					emit_q <= 1'b0;
					tail_v_q <= 1'b0;
					pend_data_q <= '0;
					pend_cnt_q <= '0;
					state_q <= S_PEND;
					if (ch_q == cle_pkg::CH_INTR) begin
						pend_v_q <= 1'b1;
						pend_kind_q <= cle_pkg::K_INTR;
					end else if (!canon_q) begin
						emit_q <= 1'b1;
						tail_v_q <= 1'b1;
						tail_kind_q <= cle_pkg::K_LINE;
						tail_data_q <= ch_q;
					end else if (c_canon inside {cle_pkg::CH_BS, cle_pkg::CH_DEL}) begin
						pend_kind_q <= cle_pkg::K_ERASE;
						pend_cnt_q <= cle_pkg::LEN_W'(1);
						if (len_q != '0) begin
							len_q <= len_q - cle_pkg::LEN_W'(1);
							pend_v_q <= echo_q;
						end
					end else if (c_canon == cle_pkg::CH_KWORD) begin
						before_q <= len_q;
						phase_q <= 1'b0;
						state_q <= S_KW0;
					end else if (c_canon == cle_pkg::CH_KLINE) begin
						len_q <= '0;
						pend_v_q <= echo_q && (len_q != '0);
						pend_kind_q <= cle_pkg::K_ERASE;
						pend_cnt_q <= len_q;
					end else if (c_canon == cle_pkg::CH_FF) begin
						if (len_q == '0) begin
							pend_v_q <= echo_q;
							pend_kind_q <= cle_pkg::K_CLEAR;
							tail_v_q <= 1'b1;
							tail_kind_q <= cle_pkg::K_EMPTY;
							tail_data_q <= '0;
						end
					end else if (c_canon == cle_pkg::CH_EOF) begin
						len_q <= '0;
						pend_v_q <= 1'b1;
						pend_kind_q <= cle_pkg::K_EOF;
					end else begin
						pend_v_q <= echo_q;
						pend_kind_q <= cle_pkg::K_ECHO;
						pend_data_q <= c_canon;
						len_q <= new_len;
						emit_q <= (c_canon == cle_pkg::CH_LF) || (new_len >= lim);
					end
				end
				S_PEND: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q <= after_pend;
					end
				end
				S_EMIT0: begin
					k_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						k_q <= k_q + cle_pkg::LEN_W'(1);
						if (k_last) begin
							len_q <= '0;
							state_q <= tail_v_q ? S_TAIL : S_IDLE;
						end
					end
				end
				S_TAIL: begin
					if (out_free) begin
						tail_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_KW0: begin
					state_q <= S_KW;
				end
				S_KW: begin
					if (kw_done) begin
						pend_v_q <= echo_q && (before_q != len_q);
						pend_kind_q <= cle_pkg::K_ERASE;
						pend_cnt_q <= before_q - len_q;
						state_q <= S_PEND;
					end else if (kw_dec) begin
						len_q <= len_q - cle_pkg::LEN_W'(1);
					end else begin
						phase_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/cle_checker.sv =====
// Port-level assertions for the canonical line editor and their binding.
`default_nettype none
module cle_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tx_valid,
	input wire logic tx_ready,
	input wire logic [2:0] tx_kind,
	input wire logic [7:0] tx_data,
	input wire logic [5:0] tx_erase_count,
	input wire logic tx_last
);

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_kind) && $stable(tx_data)
			&& $stable(tx_erase_count) && $stable(tx_last))
		else $error("Stalled result changed before it was taken.");

	a_erase_count: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_kind == cle_pkg::K_ERASE |-> tx_erase_count != 6'd0)
		else $error("Erase result carries a zero count.");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_kind != cle_pkg::K_ERASE |-> tx_erase_count == 6'd0)
		else $error("Non-erase result carries an erase count.");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (tx_kind == cle_pkg::K_INTR || tx_kind == cle_pkg::K_EOF
			|| tx_kind == cle_pkg::K_EMPTY) |-> tx_last)
		else $error("Interrupt, end-of-file or empty line result is not final.");

	a_clear_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_kind == cle_pkg::K_CLEAR |-> !tx_last)
		else $error("Clear-screen result is marked final.");

endmodule

bind canonical_line_editor_core cle_checker u_cle_checker (
	.clk(clk),
	.arst_n(arst_n),
	.tx_valid(tx.valid),
	.tx_ready(tx.ready),
	.tx_kind(tx.kind),
	.tx_data(tx.data),
	.tx_erase_count(tx.erase_count),
	.tx_last(tx.last)
);
`default_nettype wire
